// ----- hdl/json_token_serializer_assert.svh -----
// ----------------------------------------------------------------------------
// json_token_serializer_assert.svh
// assertion macros shared by the serializer rtl
// ----------------------------------------------------------------------------
`ifndef JSON_TOKEN_SERIALIZER_ASSERT_SVH
`define JSON_TOKEN_SERIALIZER_ASSERT_SVH

// property must hold on every clock outside reset
`define JTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expression must never be true outside reset
`define JTS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ----- hdl/jts_pkg.sv -----
// ----------------------------------------------------------------------------
// jts_pkg
// types, codes and text helpers for the json token serializer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jts_pkg;

  localparam int unsigned MAX_DEPTH_DEFAULT = 16;
  localparam int unsigned NUM_DIGITS        = 20;

  // configuration register indexes
  localparam logic [0:0] CFG_PRETTY_PRINT  = 1'd0;
  localparam logic [0:0] CFG_PACKED_LAYOUT = 1'd1;

  typedef enum logic [3:0] {
    OP_OBJ_BEGIN  = 4'd0,
    OP_OBJ_END    = 4'd1,
    OP_ARR_BEGIN  = 4'd2,
    OP_ARR_END    = 4'd3,
    OP_NAME_BEGIN = 4'd4,
    OP_STR_BEGIN  = 4'd5,
    OP_CHAR       = 4'd6,
    OP_STR_END    = 4'd7,
    OP_INT        = 4'd8,
    OP_TRUE       = 4'd9,
    OP_FALSE      = 4'd10,
    OP_NULL       = 4'd11
  } op_e;

  typedef enum logic [2:0] {
    MODE_DOC    = 3'd0,
    MODE_OSTART = 3'd1,
    MODE_ONAME  = 3'd2,
    MODE_OVAL   = 3'd3,
    MODE_ASTART = 3'd4,
    MODE_AMID   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    SK_NONE  = 2'd0,
    SK_NAME  = 2'd1,
    SK_VALUE = 2'd2
  } sk_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERROR,
    ST_COMMA,
    ST_CSPACE,
    ST_NEWLINE,
    ST_INDENT,
    ST_BODY,
    ST_CONVERT,
    ST_SIGN,
    ST_DIGITS
  } state_e;

  typedef enum logic [2:0] {
    SEL_ZERO,
    SEL_COMMA,
    SEL_SPACE,
    SEL_NEWLINE,
    SEL_BODY,
    SEL_MINUS,
    SEL_DIGIT
  } sel_e;

  typedef enum logic [1:0] {
    MOP_KEEP,
    MOP_SET,
    MOP_PUSH,
    MOP_POP
  } mode_op_e;

  typedef struct packed {
    logic [3:0]         op;
    logic [7:0]         text_char;
    logic signed [63:0] int_value;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       error;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic     accept;
    logic     commit;
    mode_op_e mode_op;
    mode_e    new_mode;
    mode_e    stack_val;
    logic     sk_we;
    sk_e      new_sk;
    logic     nl;
    logic     nl_close;
    logic     push;
    sel_e     sel;
    logic     last;
    logic     err;
    logic     body_inc;
    logic     ind_dec;
    logic     dig_load;
    logic     dig_dec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_e mode;
    sk_e   sk;
    logic  pretty;
    logic  packed_lay;
    logic  depth_zero;
    logic  depth_full;
    logic  can_push;
    logic  body_last;
    logic  ind_zero;
    logic  ind_one;
    logic  conv_done;
    logic  neg;
    logic  dig_last;
  } status_t;

  function automatic logic [7:0] short_esc(input logic [7:0] ch);
    logic [7:0] r;
    unique case (ch)
      8'h08:   r = "b";
      8'h09:   r = "t";
      8'h0A:   r = "n";
      8'h0C:   r = "f";
      8'h0D:   r = "r";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_up(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'h0, nib};
    end else begin
      r = 8'h37 + {4'h0, nib};
    end
    return r;
  endfunction

  function automatic logic is_quote_bs(input logic [7:0] ch);
    return (ch == 8'h22) || (ch == 8'h5C);
  endfunction

  // number of bytes of a token's own text (prefixes and integers excluded)
  function automatic logic [2:0] body_len(input logic [3:0] op, input logic [7:0] ch,
                                          input sk_e sk, input logic pretty);
    logic [2:0] r;
    unique case (op)
      OP_CHAR: begin
        if (is_quote_bs(ch)) begin
          r = 3'd2;
        end else if (ch < 8'h20) begin
          r = (short_esc(ch) != 8'h00) ? 3'd2 : 3'd6;
        end else begin
          r = 3'd1;
        end
      end
      OP_STR_END: r = (sk == SK_NAME) ? (pretty ? 3'd3 : 3'd2) : 3'd1;
      OP_TRUE:    r = 3'd4;
      OP_FALSE:   r = 3'd5;
      OP_NULL:    r = 3'd4;
      default:    r = 3'd1;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] body_byte(input logic [3:0] op, input logic [7:0] ch,
                                           input logic [2:0] idx);
    logic [7:0] r;
    r = 8'h00;
    unique case (op)
      OP_OBJ_BEGIN: r = "{";
      OP_OBJ_END:   r = "}";
      OP_ARR_BEGIN: r = "[";
      OP_ARR_END:   r = "]";
      OP_CHAR: begin
        if (is_quote_bs(ch)) begin
          r = (idx == 3'd0) ? 8'h5C : ch;
        end else if (ch < 8'h20) begin
          if (short_esc(ch) != 8'h00) begin
            r = (idx == 3'd0) ? 8'h5C : short_esc(ch);
          end else begin
            unique case (idx)
              3'd0:    r = 8'h5C;
              3'd1:    r = "u";
              3'd2:    r = "0";
              3'd3:    r = "0";
              3'd4:    r = hex_up(ch[7:4]);
              default: r = hex_up(ch[3:0]);
            endcase
          end
        end else begin
          r = ch;
        end
      end
      OP_STR_END: begin
        unique case (idx)
          3'd0:    r = 8'h22;
          3'd1:    r = ":";
          default: r = " ";
        endcase
      end
      OP_TRUE: begin
        unique case (idx)
          3'd0:    r = "t";
          3'd1:    r = "r";
          3'd2:    r = "u";
          default: r = "e";
        endcase
      end
      OP_FALSE: begin
        unique case (idx)
          3'd0:    r = "f";
          3'd1:    r = "a";
          3'd2:    r = "l";
          3'd3:    r = "s";
          default: r = "e";
        endcase
      end
      OP_NULL: begin
        unique case (idx)
          3'd0:    r = "n";
          3'd1:    r = "u";
          default: r = "l";
        endcase
      end
      default: r = 8'h22;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/jts_ctrl.sv -----
// ----------------------------------------------------------------------------
// jts_ctrl
// token checker and byte sequencing state machine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jts_ctrl
  import jts_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic [3:0] op_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   comma_q, comma_d;
  logic   csp_q, csp_d;
  logic   nl_q, nl_d;
  logic   int_q, int_d;

  logic   bad;
  logic   pn;
  mode_e  m_after;
  logic   bv_comma;
  logic   bv_nl;
  state_e body_st;

  // state and prefix flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      comma_q <= 1'b0;
      csp_q   <= 1'b0;
      nl_q    <= 1'b0;
      int_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      comma_q <= comma_d;
      csp_q   <= csp_d;
      nl_q    <= nl_d;
      int_q   <= int_d;
    end
  end

  // token legality in the current mode
  always_comb begin
    bad = 1'b0;
    if (op_i > OP_NULL) begin
      bad = 1'b1;
    end else if (status_i.sk != SK_NONE) begin
      bad = !((op_i == OP_CHAR) || (op_i == OP_STR_END));
    end else begin
      unique case (op_i)
        OP_OBJ_BEGIN, OP_ARR_BEGIN:
          bad = (status_i.mode == MODE_ONAME) || status_i.depth_full;
        OP_OBJ_END:
          bad = !((status_i.mode == MODE_OSTART) || (status_i.mode == MODE_ONAME))
                || status_i.depth_zero;
        OP_ARR_END:
          bad = !((status_i.mode == MODE_ASTART) || (status_i.mode == MODE_AMID))
                || status_i.depth_zero;
        OP_NAME_BEGIN:
          bad = !((status_i.mode == MODE_OSTART) || (status_i.mode == MODE_ONAME));
        OP_CHAR, OP_STR_END:
          bad = 1'b1;
        default:
          bad = (status_i.mode == MODE_ONAME);
      endcase
    end
  end

  // separator rules for a value
  always_comb begin
    pn       = status_i.pretty && !status_i.packed_lay;
    bv_comma = (status_i.mode == MODE_AMID);
    bv_nl    = pn && ((status_i.mode == MODE_AMID) || (status_i.mode == MODE_ASTART));
    if (status_i.mode == MODE_OVAL) begin
      m_after = MODE_ONAME;
    end else if (status_i.mode == MODE_ASTART) begin
      m_after = MODE_AMID;
    end else begin
      m_after = status_i.mode;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    comma_d    = comma_q;
    csp_d      = csp_q;
    nl_d       = nl_q;
    int_d      = int_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    body_st    = int_q ? ST_CONVERT : ST_BODY;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          comma_d      = 1'b0;
          nl_d         = 1'b0;
          int_d        = 1'b0;
          if (bad) begin
            state_d = ST_ERROR;
          end else begin
            cmd_o.commit = 1'b1;
            unique case (op_i)
              OP_OBJ_BEGIN, OP_ARR_BEGIN: begin
                comma_d         = bv_comma;
                nl_d            = bv_nl;
                cmd_o.mode_op   = MOP_PUSH;
                cmd_o.stack_val = m_after;
                cmd_o.new_mode  = (op_i == OP_OBJ_BEGIN) ? MODE_OSTART : MODE_ASTART;
              end
              OP_OBJ_END, OP_ARR_END: begin
                nl_d           = pn;
                cmd_o.nl_close = 1'b1;
                cmd_o.mode_op  = MOP_POP;
              end
              OP_NAME_BEGIN: begin
                comma_d        = (status_i.mode == MODE_ONAME);
                nl_d           = pn;
                cmd_o.mode_op  = MOP_SET;
                cmd_o.new_mode = MODE_OVAL;
                cmd_o.sk_we    = 1'b1;
                cmd_o.new_sk   = SK_NAME;
              end
              OP_STR_BEGIN: begin
                comma_d        = bv_comma;
                nl_d           = bv_nl;
                cmd_o.mode_op  = MOP_SET;
                cmd_o.new_mode = m_after;
                cmd_o.sk_we    = 1'b1;
                cmd_o.new_sk   = SK_VALUE;
              end
              OP_CHAR: begin
                cmd_o.mode_op = MOP_KEEP;
              end
              OP_STR_END: begin
                cmd_o.sk_we  = 1'b1;
                cmd_o.new_sk = SK_NONE;
              end
              default: begin
                comma_d        = bv_comma;
                nl_d           = bv_nl;
                int_d          = (op_i == OP_INT);
                cmd_o.mode_op  = MOP_SET;
                cmd_o.new_mode = m_after;
              end
            endcase
            csp_d    = comma_d && status_i.pretty && status_i.packed_lay;
            cmd_o.nl = nl_d;
            if (comma_d) begin
              state_d = ST_COMMA;
            end else if (nl_d) begin
              state_d = ST_NEWLINE;
            end else begin
              state_d = int_d ? ST_CONVERT : ST_BODY;
            end
          end
        end
      end

      ST_ERROR: begin
        cmd_o.sel  = SEL_ZERO;
        cmd_o.last = 1'b1;
        cmd_o.err  = 1'b1;
        if (status_i.can_push) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      ST_COMMA: begin
        cmd_o.sel = SEL_COMMA;
        if (status_i.can_push) begin
          cmd_o.push = 1'b1;
          if (csp_q) begin
            state_d = ST_CSPACE;
          end else if (nl_q) begin
            state_d = ST_NEWLINE;
          end else begin
            state_d = body_st;
          end
        end
      end

      ST_CSPACE: begin
        cmd_o.sel = SEL_SPACE;
        if (status_i.can_push) begin
          cmd_o.push = 1'b1;
          state_d    = nl_q ? ST_NEWLINE : body_st;
        end
      end

      ST_NEWLINE: begin
        cmd_o.sel = SEL_NEWLINE;
        if (status_i.can_push) begin
          cmd_o.push = 1'b1;
          state_d    = status_i.ind_zero ? body_st : ST_INDENT;
        end
      end

      ST_INDENT: begin
        cmd_o.sel = SEL_SPACE;
        if (status_i.can_push) begin
          cmd_o.push    = 1'b1;
          cmd_o.ind_dec = 1'b1;
          if (status_i.ind_one) begin
            state_d = body_st;
          end
        end
      end

      ST_BODY: begin
        cmd_o.sel  = SEL_BODY;
        cmd_o.last = status_i.body_last;
        if (status_i.can_push) begin
          cmd_o.push     = 1'b1;
          cmd_o.body_inc = 1'b1;
          if (status_i.body_last) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_CONVERT: begin
        if (status_i.conv_done) begin
          cmd_o.dig_load = 1'b1;
          state_d        = status_i.neg ? ST_SIGN : ST_DIGITS;
        end
      end

      ST_SIGN: begin
        cmd_o.sel = SEL_MINUS;
        if (status_i.can_push) begin
          cmd_o.push = 1'b1;
          state_d    = ST_DIGITS;
        end
      end

      ST_DIGITS: begin
        cmd_o.sel  = SEL_DIGIT;
        cmd_o.last = status_i.dig_last;
        if (status_i.can_push) begin
          cmd_o.push    = 1'b1;
          cmd_o.dig_dec = 1'b1;
          if (status_i.dig_last) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/jts_dp.sv -----
// ----------------------------------------------------------------------------
// jts_dp
// writer state, mode stack, decimal converter and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jts_dp
  import jts_pkg::*;
#(
  parameter int unsigned MaxDepth = MAX_DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [0:0] cfg_data_i,
  input  in_t        in_data_i,
  input  cmd_t       cmd_i,
  output status_t    status_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o
);

  localparam int unsigned DepthW = $clog2(MaxDepth + 1);
  localparam int unsigned StkW   = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;
  localparam int unsigned IndW   = $clog2(2 * MaxDepth + 1);
  localparam int unsigned BcdW   = 4 * NUM_DIGITS;
  localparam int unsigned DigW   = $clog2(NUM_DIGITS);

  logic              pretty_q, packed_q;
  mode_e             mode_q;
  sk_e               sk_q;
  logic [DepthW-1:0] depth_q;
  logic [DepthW-1:0] depth_m1;
  mode_e             stack_q [MaxDepth];

  logic [3:0]        tok_op_q;
  logic [7:0]        tok_ch_q;
  sk_e               tok_sk_q;
  logic              tok_pretty_q;
  logic [2:0]        body_idx_q;
  logic [2:0]        blen;
  logic [IndW-1:0]   ind_q;
  logic [DepthW-1:0] ind_depth;

  logic [63:0]       mag_q;
  logic [BcdW-1:0]   bcd_q;
  logic [BcdW-1:0]   bcd_adj;
  logic [6:0]        conv_cnt_q;
  logic              neg_q;
  logic [DigW-1:0]   dig_idx_q;
  logic [DigW-1:0]   msd;
  logic [3:0]        dig_nib;

  logic              out_valid_q;
  out_t              out_q;
  logic [7:0]        byte_sel;
  logic              can_push;

  assign depth_m1  = depth_q - DepthW'(1);
  assign ind_depth = cmd_i.nl_close ? depth_m1 : depth_q;
  assign can_push  = !out_valid_q || out_ready_i;
  assign blen      = body_len(tok_op_q, tok_ch_q, tok_sk_q, tok_pretty_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pretty_q <= 1'b0;
      packed_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PRETTY_PRINT:  pretty_q <= cfg_data_i[0];
        CFG_PACKED_LAYOUT: packed_q <= cfg_data_i[0];
        default:           pretty_q <= pretty_q;
      endcase
    end
  end

  // writer mode, string kind and depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_DOC;
      sk_q    <= SK_NONE;
      depth_q <= '0;
    end else if (cmd_i.commit) begin
      if (cmd_i.sk_we) begin
        sk_q <= cmd_i.new_sk;
      end
      unique case (cmd_i.mode_op)
        MOP_SET:  mode_q <= cmd_i.new_mode;
        MOP_PUSH: begin
          mode_q  <= cmd_i.new_mode;
          depth_q <= depth_q + DepthW'(1);
        end
        MOP_POP: begin
          mode_q  <= stack_q[depth_m1[StkW-1:0]];
          depth_q <= depth_m1;
        end
        default: mode_q <= mode_q;
      endcase
    end
  end

  // mode stack, written only by a push
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (cmd_i.mode_op == MOP_PUSH)) begin
      stack_q[depth_q[StkW-1:0]] <= cmd_i.stack_val;
    end
  end

  // token latch and body / indent counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tok_op_q     <= in_data_i.op;
      tok_ch_q     <= in_data_i.text_char;
      tok_sk_q     <= sk_q;
      tok_pretty_q <= pretty_q;
      body_idx_q   <= '0;
      ind_q        <= cmd_i.nl ? IndW'({ind_depth, 1'b0}) : '0;
    end else begin
      if (cmd_i.body_inc) begin
        body_idx_q <= body_idx_q + 3'd1;
      end
      if (cmd_i.ind_dec) begin
        ind_q <= ind_q - IndW'(1);
      end
    end
  end

  // shift-add-3 binary to decimal, one bit a cycle
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                   : bcd_q[4*i +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_cnt_q <= '0;
    end else if (cmd_i.accept) begin
      conv_cnt_q <= 7'd64;
    end else if (conv_cnt_q != 7'd0) begin
      conv_cnt_q <= conv_cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      neg_q <= in_data_i.int_value[63];
      mag_q <= in_data_i.int_value[63] ? (~in_data_i.int_value + 64'd1)
                                       : in_data_i.int_value;
      bcd_q <= '0;
    end else if (conv_cnt_q != 7'd0) begin
      bcd_q <= {bcd_adj[BcdW-2:0], mag_q[63]};
      mag_q <= {mag_q[62:0], 1'b0};
    end
  end

  // most significant nonzero digit
  always_comb begin
    msd = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        msd = DigW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dig_load) begin
      dig_idx_q <= msd;
    end else if (cmd_i.dig_dec) begin
      dig_idx_q <= dig_idx_q - DigW'(1);
    end
  end

  assign dig_nib = bcd_q[{dig_idx_q, 2'b00} +: 4];

  // output byte select
  always_comb begin
    unique case (cmd_i.sel)
      SEL_COMMA:   byte_sel = ",";
      SEL_SPACE:   byte_sel = " ";
      SEL_NEWLINE: byte_sel = 8'h0A;
      SEL_BODY:    byte_sel = body_byte(tok_op_q, tok_ch_q, body_idx_q);
      SEL_MINUS:   byte_sel = "-";
      SEL_DIGIT:   byte_sel = 8'h30 | {4'h0, dig_nib};
      default:     byte_sel = 8'h00;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q.out_byte  <= byte_sel;
      out_q.last_byte <= cmd_i.last;
      out_q.error     <= cmd_i.err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // status to the controller
  always_comb begin
    status_o.mode       = mode_q;
    status_o.sk         = sk_q;
    status_o.pretty     = pretty_q;
    status_o.packed_lay = packed_q;
    status_o.depth_zero = (depth_q == '0);
    status_o.depth_full = (depth_q >= DepthW'(MaxDepth));
    status_o.can_push   = can_push;
    status_o.body_last  = (body_idx_q == (blen - 3'd1));
    status_o.ind_zero   = (ind_q == '0);
    status_o.ind_one    = (ind_q == IndW'(1));
    status_o.conv_done  = (conv_cnt_q == 7'd0);
    status_o.neg        = neg_q;
    status_o.dig_last   = (dig_idx_q == '0);
  end

endmodule

// ----- hdl/json_token_serializer.sv -----
// ----------------------------------------------------------------------------
// json_token_serializer
// json tokens in, escaped and formatted text out one byte per beat
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  in        in   in_valid_i/in_ready_o   in_t  (op, text_char, int_value)
//  out       out  out_valid_o/out_ready_i out_t (out_byte, last_byte, error)
//  cfg       in   cfg_we_i                cfg_index_i, cfg_data_i
//
//  one token at a time; a token is accepted in the idle state, then its beats go out
//  one per cycle unless the out channel stalls; an integer first needs 64 shift-add-3
//  steps and a digit load, overlapped by any comma, space, newline and indent beats.
//  a new token is taken once the last beat of the previous one is in the
//  output register; a stalled out channel holds the sequencer.
//  reset clears mode, depth, string state and the config registers.
`timescale 1ns / 1ps

module json_token_serializer
  import jts_pkg::*;
#(
  parameter int unsigned MaxDepth = MAX_DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [0:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o
);

`include "json_token_serializer_assert.svh"

  cmd_t    cmd;
  status_t status;

  // sequencer
  jts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (in_data_i.op),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  jts_dp #(
    .MaxDepth (MaxDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // checks
  `JTS_ASSERT(a_err_beat_form, out_valid_o && out_data_o.error |-> out_data_o.last_byte && (out_data_o.out_byte == 8'h00), "error beat must be a last zero byte")
  `JTS_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "token accepted without producing a beat")
  `JTS_ASSERT_NEVER(a_push_when_idle, in_ready_o && cmd.push, "beat pushed while idle")

endmodule
